@@ hdl/ffse_pkg.sv @@
package ffse_pkg;

  localparam int GRID_DIM_DEF   = 16;
  localparam int LABEL_BITS_DEF = 8;
  localparam int EMIT_MAX       = 16;   // widest row mask / most rows in use
  localparam int COORD_W        = 4;
  localparam int CFG_W          = 5;

  // configuration register indexes
  typedef enum logic {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_t;

  // neighbour step order: up, down, left, right
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_CHK,
    S_CLEAR,
    S_INIT,
    S_POP,
    S_POP_WAIT,
    S_NB_RD,
    S_NB_CHK,
    S_EM_RD,
    S_EM_OUT,
    S_EMPTY
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load_we;
    logic seed_take;
    logic tgt_take;
    logic clr_we;
    logic init;
    logic pop;
    logic cell_take;
    logic dir_inc;
    logic nb_chk;
    logic em_start;
    logic em_rd;
    logic em_inc;
    logic out_row;
    logic out_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_action;
    logic seed_oob;
    logic seed_bad;
    logic clr_last;
    logic q_empty;
    logic nb_ok;
    logic dir_last;
    logic em_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/ffse_if.sv @@
interface ffse_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [ffse_pkg::COORD_W-1:0]      pos_x;
  logic [ffse_pkg::COORD_W-1:0]      pos_y;
  logic signed [7:0]                 cell_label;

  modport source (output valid, action, pos_x, pos_y, cell_label, input ready);
  modport sink   (input valid, action, pos_x, pos_y, cell_label, output ready);
endinterface

interface ffse_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [6:0]  shape_label;
  logic [4:0]  shape_height;
  logic [4:0]  shape_width;
  logic [3:0]  row_index;
  logic [15:0] row_mask;
  logic        last;

  modport source (output valid, found, shape_label, shape_height, shape_width,
                  row_index, row_mask, last, input ready);
  modport sink   (input valid, found, shape_label, shape_height, shape_width,
                  row_index, row_mask, last, output ready);
endinterface

interface ffse_cfg_if;
  logic                          valid;
  logic                          ready;
  logic                          index;
  logic [ffse_pkg::CFG_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/flood_fill_shape_extract.sv @@
// Shape extraction by 4-connected flood fill over a label grid.
// Channels: item_in takes load items (action 0: write cell_label at
// pos_x/pos_y) and extract items (action 1: seed cell); result_out gives
// result items; cfg writes grid_rows (index 0) and grid_cols (index 1),
// saturated to 1..16. All are valid/ready; an item moves when both are high.
// Loads give no result. An extract with a seed outside the rows/columns
// in use gives one empty result; so does one whose seed label, read from
// the label store, is zero or below. Otherwise the block clears its visited
// rows, then walks the fill queue: it pops each queued cell, then reads the
// label and visited row of each neighbour inside the rows/columns in use
// (from single-port stores) and skips each neighbour outside them. Then it
// gives one result per bounding box row.
// The next item is taken once the last result sits in the output register.
// A stalled receiver holds the output register; the block re-reads the
// pending row and waits on it.
// Reset (synchronous, rst high) returns to idle with the grid size at 16x16;
// the label store is not cleared, and an unloaded cell must not be read.
module flood_fill_shape_extract #(
  parameter int GRID_DIM   = ffse_pkg::GRID_DIM_DEF,
  parameter int LABEL_BITS = ffse_pkg::LABEL_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  ffse_in_if.sink     item_in,
  ffse_out_if.source  result_out,
  ffse_cfg_if.sink    cfg
);

  ffse_pkg::ctrl_cmd_t  cmd;
  ffse_pkg::dp_status_t status;

  // sequencer: fill and emit phases
  ffse_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // stores, queue, bounding box and result register
  ffse_dp #(
    .GRID_DIM   (GRID_DIM),
    .LABEL_BITS (LABEL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

@@ hdl/ffse_ctrl.sv @@
module ffse_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  ffse_pkg::dp_status_t   status,
  output ffse_pkg::ctrl_cmd_t    cmd
);

  ffse_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffse_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ffse_pkg::S_IDLE: begin
        if (status.in_valid && status.in_action) begin
          state_next = status.seed_oob ? ffse_pkg::S_EMPTY : ffse_pkg::S_SEED_CHK;
        end
      end
      ffse_pkg::S_SEED_CHK: state_next = status.seed_bad ? ffse_pkg::S_EMPTY
                                                          : ffse_pkg::S_CLEAR;
      ffse_pkg::S_CLEAR: begin
        if (status.clr_last) state_next = ffse_pkg::S_INIT;
      end
      ffse_pkg::S_INIT: state_next = ffse_pkg::S_POP;
      ffse_pkg::S_POP: state_next = status.q_empty ? ffse_pkg::S_EM_RD
                                                    : ffse_pkg::S_POP_WAIT;
      ffse_pkg::S_POP_WAIT: state_next = ffse_pkg::S_NB_RD;
      ffse_pkg::S_NB_RD: begin
        if (status.nb_ok) state_next = ffse_pkg::S_NB_CHK;
        else if (status.dir_last) state_next = ffse_pkg::S_POP;
      end
      ffse_pkg::S_NB_CHK: state_next = status.dir_last ? ffse_pkg::S_POP
                                                        : ffse_pkg::S_NB_RD;
      ffse_pkg::S_EM_RD: state_next = ffse_pkg::S_EM_OUT;
      ffse_pkg::S_EM_OUT: begin
        if (status.out_free) begin
          state_next = status.em_last ? ffse_pkg::S_IDLE : ffse_pkg::S_EM_RD;
        end else begin
          // row read data is overwritten while waiting, so fetch it again
          state_next = ffse_pkg::S_EM_RD;
        end
      end
      ffse_pkg::S_EMPTY: begin
        if (status.out_free) state_next = ffse_pkg::S_IDLE;
      end
      default: state_next = ffse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ffse_pkg::S_IDLE: begin
        cmd.in_ready  = 1'b1;
        cmd.load_we   = status.in_valid && !status.in_action;
        cmd.seed_take = status.in_valid && status.in_action;
      end
      ffse_pkg::S_SEED_CHK: cmd.tgt_take = 1'b1;
      ffse_pkg::S_CLEAR:    cmd.clr_we   = 1'b1;
      ffse_pkg::S_INIT:     cmd.init     = 1'b1;
      ffse_pkg::S_POP: begin
        cmd.pop      = !status.q_empty;
        cmd.em_start = status.q_empty;
      end
      ffse_pkg::S_POP_WAIT: cmd.cell_take = 1'b1;
      ffse_pkg::S_NB_RD:    cmd.dir_inc   = !status.nb_ok;
      ffse_pkg::S_NB_CHK: begin
        cmd.nb_chk  = 1'b1;
        cmd.dir_inc = 1'b1;
      end
      ffse_pkg::S_EM_RD:    cmd.em_rd = 1'b1;
      ffse_pkg::S_EM_OUT: begin
        cmd.out_row = status.out_free;
        cmd.em_inc  = status.out_free;
      end
      ffse_pkg::S_EMPTY:    cmd.out_empty = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hdl/ffse_dp.sv @@
module ffse_dp #(
  parameter int GRID_DIM   = ffse_pkg::GRID_DIM_DEF,
  parameter int LABEL_BITS = ffse_pkg::LABEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ffse_in_if.sink               item_in,
  ffse_out_if.source            result_out,
  ffse_cfg_if.sink              cfg,
  input  ffse_pkg::ctrl_cmd_t   cmd,
  output ffse_pkg::dp_status_t  status
);

  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int CAP   = (GRID_DIM < ffse_pkg::EMIT_MAX) ? GRID_DIM : ffse_pkg::EMIT_MAX;
  localparam int QD    = CAP * CAP;
  localparam int QIW   = $clog2(QD);
  localparam int QCW   = $clog2(QD + 1);
  localparam int CW    = ffse_pkg::COORD_W;
  localparam int MW    = ffse_pkg::EMIT_MAX;

  // memories
  logic [LABEL_BITS-1:0] lab_mem [CELLS];
  logic [MW-1:0]         vis_mem [MW];
  logic [2*CW-1:0]       q_mem   [QD];

  logic [LABEL_BITS-1:0] lab_q;
  logic [MW-1:0]         vis_q;
  logic [2*CW-1:0]       q_q;

  logic [ffse_pkg::CFG_W-1:0] rows, cols;
  logic [CW-1:0] sx, sy, cx, cy, nx, ny;
  logic [CW-1:0] minx, maxx, miny, maxy;
  logic [LABEL_BITS-1:0] target;
  logic [CW-1:0] clr_cnt, er;
  logic [1:0]    dir;
  logic [QCW-1:0] head, tail;
  logic          nb_ok, push;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    cell_addr = AW'(y) * AW'(GRID_DIM) + AW'(x);
  endfunction

  function automatic logic [ffse_pkg::CFG_W-1:0] clip(input logic [ffse_pkg::CFG_W-1:0] v);
    if (v == '0) clip = ffse_pkg::CFG_W'(1);
    else if (int'(v) > CAP) clip = ffse_pkg::CFG_W'(CAP);
    else clip = v;
  endfunction

  // configuration
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= ffse_pkg::CFG_W'(CAP);
      cols <= ffse_pkg::CFG_W'(CAP);
    end else if (cfg.valid) begin
      if (cfg.index == ffse_pkg::REG_GRID_ROWS) rows <= clip(cfg.data);
      else cols <= clip(cfg.data);
    end
  end

  assign item_in.ready = cmd.in_ready;

  // label store: write on load, one read port (seed or neighbour)
  always_ff @(posedge clk) begin
    if (cmd.load_we && int'(item_in.pos_x) < GRID_DIM && int'(item_in.pos_y) < GRID_DIM) begin
      lab_mem[cell_addr(item_in.pos_x, item_in.pos_y)] <= LABEL_BITS'(item_in.cell_label);
    end
    lab_q <= cmd.seed_take ? lab_mem[cell_addr(item_in.pos_x, item_in.pos_y)]
                           : lab_mem[cell_addr(nx, ny)];
  end

  // neighbour of the current cell
  always_comb begin
    nx = cx;
    ny = cy;
    nb_ok = 1'b0;
    case (ffse_pkg::dir_t'(dir))
      ffse_pkg::DIR_UP: begin
        ny = cy - 1'b1;
        nb_ok = (cy != '0);
      end
      ffse_pkg::DIR_DOWN: begin
        ny = cy + 1'b1;
        nb_ok = ({1'b0, cy} + 5'd1) < rows;
      end
      ffse_pkg::DIR_LEFT: begin
        nx = cx - 1'b1;
        nb_ok = (cx != '0);
      end
      ffse_pkg::DIR_RIGHT: begin
        nx = cx + 1'b1;
        nb_ok = ({1'b0, cx} + 5'd1) < cols;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign push = cmd.nb_chk && (lab_q == target) && !vis_q[nx];

  // visited rows: clear sweep, seed mark, read-modify-write on push
  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      vis_mem[clr_cnt] <= '0;
    end else if (cmd.init) begin
      vis_mem[sy] <= MW'(1) << sx;
    end else if (push) begin
      vis_mem[ny] <= vis_q | (MW'(1) << nx);
    end
    vis_q <= cmd.em_rd ? vis_mem[miny + er] : vis_mem[ny];
  end

  // fill queue
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      q_mem[QIW'(0)] <= {sy, sx};
    end else if (push) begin
      q_mem[tail[QIW-1:0]] <= {ny, nx};
    end
    q_q <= q_mem[head[QIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      clr_cnt <= '0;
      dir     <= '0;
      er      <= '0;
      target  <= '0;
      minx    <= '0;
      maxx    <= '0;
      miny    <= '0;
      maxy    <= '0;
    end else begin
      if (cmd.tgt_take) target <= lab_q;
      if (cmd.clr_we) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.init) begin
        head <= '0;
        tail <= QCW'(1);
        minx <= sx;
        maxx <= sx;
        miny <= sy;
        maxy <= sy;
      end
      if (cmd.pop) head <= head + 1'b1;
      if (push) tail <= tail + 1'b1;
      if (cmd.cell_take) begin
        dir <= '0;
        if (q_q[CW-1:0] < minx) minx <= q_q[CW-1:0];
        if (q_q[CW-1:0] > maxx) maxx <= q_q[CW-1:0];
        if (q_q[2*CW-1:CW] < miny) miny <= q_q[2*CW-1:CW];
        if (q_q[2*CW-1:CW] > maxy) maxy <= q_q[2*CW-1:CW];
      end else if (cmd.dir_inc) begin
        dir <= dir + 1'b1;
      end
      if (cmd.em_start) er <= '0;
      else if (cmd.em_inc) er <= er + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_take) begin
      sx <= item_in.pos_x;
      sy <= item_in.pos_y;
    end
    if (cmd.cell_take) begin
      cx <= q_q[CW-1:0];
      cy <= q_q[2*CW-1:CW];
    end
  end

  // result register
  logic out_free;
  logic [CW-1:0] span_x;
  assign out_free = !result_out.valid || result_out.ready;
  assign span_x   = maxx - minx;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (cmd.out_row || cmd.out_empty) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_empty) begin
      result_out.found        <= 1'b0;
      result_out.shape_label  <= '0;
      result_out.shape_height <= '0;
      result_out.shape_width  <= '0;
      result_out.row_index    <= '0;
      result_out.row_mask     <= '0;
      result_out.last         <= 1'b1;
    end else if (cmd.out_row) begin
      result_out.found        <= 1'b1;
      result_out.shape_label  <= 7'(target);
      result_out.shape_height <= {1'b0, maxy - miny} + 5'd1;
      result_out.shape_width  <= {1'b0, span_x} + 5'd1;
      result_out.row_index    <= er;
      result_out.row_mask     <= (vis_q >> minx) & (16'hFFFF >> (4'd15 - span_x));
      result_out.last         <= (er == maxy - miny);
    end
  end

  always_comb begin
    status.in_valid  = item_in.valid;
    status.in_action = item_in.action;
    status.seed_oob  = ({1'b0, item_in.pos_x} >= cols) || ({1'b0, item_in.pos_y} >= rows);
    status.seed_bad  = lab_q[LABEL_BITS-1] || (lab_q == '0);
    status.clr_last  = (clr_cnt == '1);
    status.q_empty   = (head == tail);
    status.nb_ok     = nb_ok;
    status.dir_last  = (dir == 2'(ffse_pkg::DIR_RIGHT));
    status.em_last   = (er == maxy - miny);
    status.out_free  = out_free;
  end

endmodule

@@ hdl/ffse_checker.sv @@
module ffse_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [6:0]  shape_label,
  input logic [4:0]  shape_height,
  input logic [4:0]  shape_width,
  input logic [3:0]  row_index,
  input logic [15:0] row_mask,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_mask) && $stable(last))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last && row_mask == '0 && shape_height == '0
                            && shape_width == '0 && shape_label == '0)
    else $error("empty result not clean");

  a_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> row_mask != '0 && (({16'b0, row_mask} >> shape_width) == '0))
    else $error("row mask outside box");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (last == (5'(row_index) + 5'd1 == shape_height)))
    else $error("last flag on wrong row");

endmodule

bind flood_fill_shape_extract ffse_checker u_ffse_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .found        (result_out.found),
  .shape_label  (result_out.shape_label),
  .shape_height (result_out.shape_height),
  .shape_width  (result_out.shape_width),
  .row_index    (result_out.row_index),
  .row_mask     (result_out.row_mask),
  .last         (result_out.last)
);
